// File: hdl/ledd_pkg.sv
// Shared types and constants for the LED dimmer effect controller.
`default_nettype none

package ledd_pkg;

    localparam int LEVEL_W = 10;
    localparam int TICK_W  = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 10'd1023;
    localparam logic [TICK_W-1:0]  TICK_SAT       = 16'hFFFF;
    localparam logic [TICK_W-1:0]  STEP_INTERVAL_RST = 16'd10;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_DIM   = 3'd2,
        MODE_DIMTO = 3'd3,
        MODE_FLASH = 3'd4,
        MODE_PULSE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        CMD_ON        = 3'd0,
        CMD_OFF       = 3'd1,
        CMD_DIM_DOWN  = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_FLASH     = 3'd4,
        CMD_PULSE     = 3'd5,
        CMD_DIM_TO    = 3'd6,
        CMD_SET_LEVEL = 3'd7
    } t_cmd;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_COMMAND = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        t_cmd               command;
        logic [LEVEL_W-1:0] level_arg;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic               step_down;
        t_mode              mode;
        logic [TICK_W-1:0]  ticks;
    } t_state;

endpackage

`default_nettype wire

// File: hdl/ledd_step.sv
// Next-state logic for one request: tick counting, effect steps and commands.
`default_nettype none

module ledd_step import ledd_pkg::*; (
    input  wire t_state            i_state,
    input  wire t_item             i_item,
    input  wire [TICK_W-1:0]       i_step_interval,
    output t_state                 o_state
);

    logic [TICK_W-1:0]  ticks_inc;
    logic               effect_mode;
    logic               run_step;
    logic               pulse_dir;
    logic [LEVEL_W-1:0] moved_level;
    logic [LEVEL_W-1:0] dim_level;
    logic [LEVEL_W-1:0] arg_level;
    t_state             tick_state;
    t_state             cmd_state;

    assign ticks_inc = (i_state.ticks < TICK_SAT) ? i_state.ticks + 1'b1 : i_state.ticks;

    always_comb begin
        case (i_state.mode)
            MODE_DIM, MODE_DIMTO, MODE_FLASH, MODE_PULSE: effect_mode = 1'b1;
            default:                                      effect_mode = 1'b0;
        endcase
    end

    assign run_step = effect_mode && (ticks_inc >= i_step_interval);

    // pulse turns at the bottom, and at the target or the top
    always_comb begin
        if (i_state.level == '0) begin
            pulse_dir = 1'b0;
        end else if (i_state.level == i_state.target || i_state.level == LEVEL_MAX) begin
            pulse_dir = 1'b1;
        end else begin
            pulse_dir = i_state.step_down;
        end
    end

    // one count in the pulse direction
    always_comb begin
        if (pulse_dir) begin
            moved_level = (i_state.level != '0) ? i_state.level - 1'b1 : i_state.level;
        end else begin
            moved_level = (i_state.level != LEVEL_MAX) ? i_state.level + 1'b1 : i_state.level;
        end
    end

    // one count in the stored direction
    always_comb begin
        if (i_state.step_down) begin
            dim_level = (i_state.level != '0) ? i_state.level - 1'b1 : i_state.level;
        end else begin
            dim_level = (i_state.level != LEVEL_MAX) ? i_state.level + 1'b1 : i_state.level;
        end
    end

    always_comb begin
        tick_state       = i_state;
        tick_state.ticks = ticks_inc;
        if (run_step) begin
            tick_state.ticks = '0;
            case (i_state.mode)
                MODE_PULSE: begin
                    tick_state.step_down = pulse_dir;
                    tick_state.level     = moved_level;
                end
                MODE_DIM, MODE_DIMTO: begin
                    tick_state.level = dim_level;
                    if (dim_level == '0) begin
                        tick_state.mode = MODE_OFF;
                    end else if (dim_level == LEVEL_MAX || dim_level == i_state.target) begin
                        tick_state.mode = MODE_ON;
                    end
                end
                MODE_FLASH: begin
                    tick_state.level = (i_state.level == '0) ? i_state.target : '0;
                end
                default: begin
                    tick_state.level = i_state.level;
                end
            endcase
        end
    end

    assign arg_level = (i_item.level_arg > LEVEL_MAX) ? LEVEL_MAX : i_item.level_arg;

    always_comb begin
        cmd_state = i_state;
        unique case (i_item.command)
            CMD_ON: begin
                cmd_state.level = LEVEL_MAX;
                cmd_state.mode  = MODE_ON;
            end
            CMD_OFF: begin
                cmd_state.level = '0;
                cmd_state.mode  = MODE_OFF;
            end
            CMD_DIM_DOWN: begin
                if (i_state.level != '0) begin
                    cmd_state.target    = '0;
                    cmd_state.step_down = 1'b1;
                    cmd_state.mode      = MODE_DIM;
                end
            end
            CMD_STOP: begin
                cmd_state.mode = MODE_ON;
            end
            CMD_FLASH, CMD_PULSE: begin
                cmd_state.level  = (i_state.level == '0) ? LEVEL_MAX : i_state.level;
                cmd_state.target = (i_state.level == '0) ? LEVEL_MAX : i_state.level;
                cmd_state.mode   = (i_item.command == CMD_FLASH) ? MODE_FLASH : MODE_PULSE;
            end
            CMD_DIM_TO: begin
                cmd_state.target    = arg_level;
                cmd_state.step_down = arg_level < i_state.level;
                cmd_state.mode      = MODE_DIMTO;
            end
            CMD_SET_LEVEL: begin
                cmd_state.target = arg_level;
                cmd_state.level  = arg_level;
            end
            default: begin
                cmd_state = i_state;
            end
        endcase
    end

    assign o_state = (i_item.kind == KIND_TICK) ? tick_state : cmd_state;

endmodule

`default_nettype wire

// File: hdl/led_dimmer_effect_controller.sv
// Top level of the single-channel LED dimmer with timed effects.
//
//  channel   valid        ready        payload
//  input     i_in_valid   o_in_ready   i_kind, i_command, i_level_arg
//  output    o_out_valid  i_out_ready  o_level, o_mode
//  config    i_cfg_we     (none)       i_cfg_wdata (step interval)
//
// A request passes one input register, then the next-state logic writes the
// state register, which drives the result ports. One request per cycle is
// sustained while the receiver is ready; the state update is a single pass.
// A stalled result holds the input register; a new request enters as the
// input register moves on. Synchronous reset clears state and valid flags.
`default_nettype none

module led_dimmer_effect_controller import ledd_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_kind,
    input  wire  [2:0]         i_command,
    input  wire  [LEVEL_W-1:0] i_level_arg,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [LEVEL_W-1:0] o_level,
    output logic [2:0]         o_mode,
    input  wire                i_cfg_we,
    input  wire  [TICK_W-1:0]  i_cfg_wdata
);

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_state            r_state;
    t_state            n_state;
    logic [TICK_W-1:0] r_step_interval;
    logic              advance;
    logic              in_accept;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.kind      <= t_kind'(i_kind);
            r_item.command   <= t_cmd'(i_command);
            r_item.level_arg <= i_level_arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= STEP_INTERVAL_RST;
        end else if (i_cfg_we) begin
            r_step_interval <= i_cfg_wdata;
        end
    end

    ledd_step u_step (
        .i_state         (r_state),
        .i_item          (r_item),
        .i_step_interval (r_step_interval),
        .o_state         (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{level: '0, target: '0, step_down: 1'b0,
                             mode: MODE_OFF, ticks: '0};
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_state.level;
    assign o_mode      = r_state.mode;

    // a stalled result must keep the pending request parked
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |=> r_in_valid && $stable(r_item))
        else $error("pending request lost during output stall");

    // state only changes when a request moves into the result stage
    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a request");

    // a taken result with nothing behind it drops valid
    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !advance |=> !o_out_valid)
        else $error("result repeated");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the LED dimmer effect controller.
`timescale 1ns / 1ps

module testbench;
    import ledd_pkg::*;

    // receiver stall styles
    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_RANDOM = 2;
    localparam int RX_SPARSE = 3;

    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_mode              mode;
    } t_lamp_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = 1'b0;
    logic [2:0]         i_command = 3'd0;
    logic [LEVEL_W-1:0] i_level_arg = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [LEVEL_W-1:0] o_level;
    logic [2:0]         o_mode;
    logic               i_cfg_we = 1'b0;
    logic [TICK_W-1:0]  i_cfg_wdata = '0;

    led_dimmer_effect_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_command   (i_command),
        .i_level_arg (i_level_arg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level),
        .o_mode      (o_mode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    t_item     pending_reqs[$];
    t_lamp_out expected_lamp[$];

    // shadow of the dimmer state
    logic [LEVEL_W-1:0] m_level    = '0;
    logic [LEVEL_W-1:0] m_target   = '0;
    logic               m_down     = 1'b0;
    t_mode              m_mode     = MODE_OFF;
    logic [TICK_W-1:0]  m_ticks    = '0;
    logic [TICK_W-1:0]  m_interval = STEP_INTERVAL_RST;

    int  n_errors = 0;
    int  n_requests = 0;
    int  n_results = 0;
    int  n_cfg = 0;
    logic req_taken = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  rx_left = 0;
    int  rx_style = RX_FREE;

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void lamp_move();
        if (m_down) begin
            if (m_level != 0) m_level = m_level - 1'b1;
        end else begin
            if (m_level != LEVEL_MAX) m_level = m_level + 1'b1;
        end
    endfunction

    function automatic t_lamp_out dimmer_advance(t_kind kind, t_cmd cmd,
                                                 logic [LEVEL_W-1:0] arg);
        t_lamp_out r;
        if (kind == KIND_TICK) begin
            if (m_ticks != TICK_SAT) m_ticks = m_ticks + 1'b1;
            if (m_mode >= MODE_DIM && m_mode <= MODE_PULSE && m_ticks >= m_interval) begin
                m_ticks = '0;
                case (m_mode)
                    MODE_PULSE: begin
                        if (m_level == 0)
                            m_down = 1'b0;
                        else if (m_level == m_target || m_level == LEVEL_MAX)
                            m_down = 1'b1;
                        lamp_move();
                    end
                    MODE_DIM, MODE_DIMTO: begin
                        lamp_move();
                        if (m_level == 0)
                            m_mode = MODE_OFF;
                        else if (m_level == LEVEL_MAX || m_level == m_target)
                            m_mode = MODE_ON;
                    end
                    MODE_FLASH: m_level = (m_level == 0) ? m_target : '0;
                    default: ;
                endcase
            end
        end else begin
            case (cmd)
                CMD_ON: begin
                    m_level = LEVEL_MAX;
                    m_mode  = MODE_ON;
                end
                CMD_OFF: begin
                    m_level = '0;
                    m_mode  = MODE_OFF;
                end
                CMD_DIM_DOWN: begin
                    // no effect at all when already dark
                    if (m_level != 0) begin
                        m_target = '0;
                        m_down   = 1'b1;
                        m_mode   = MODE_DIM;
                    end
                end
                CMD_STOP: m_mode = MODE_ON;
                CMD_FLASH, CMD_PULSE: begin
                    if (m_level == 0) m_level = LEVEL_MAX;
                    m_target = m_level;
                    m_mode   = (cmd == CMD_FLASH) ? MODE_FLASH : MODE_PULSE;
                end
                CMD_DIM_TO: begin
                    m_target = arg;
                    m_down   = (arg < m_level);
                    m_mode   = MODE_DIMTO;
                end
                default: begin
                    m_target = arg;
                    m_level  = arg;
                end
            endcase
        end
        r.level = m_level;
        r.mode  = m_mode;
        return r;
    endfunction

    // request driver
    always @(negedge i_clk) begin : drive
        t_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                i_kind      <= nxt.kind;
                i_command   <= nxt.command;
                i_level_arg <= nxt.level_arg;
                i_in_valid  <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(RX_FREE, RX_SPARSE);
            rx_left  <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_HALF:   i_out_ready <= rx_left[0];
            RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
            default:   i_out_ready <= (rx_left[2:0] == 3'd0);
        endcase
    end

    // request capture, prediction and result check
    always @(posedge i_clk) begin : observe
        t_lamp_out want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_lamp.push_back(dimmer_advance(t_kind'(i_kind), t_cmd'(i_command),
                                                   i_level_arg));
            n_requests++;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_lamp.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_lamp.pop_front();
                if (o_level !== want.level)
                    report_mismatch($sformatf("level %0d, expected %0d", o_level, want.level));
                if (o_mode !== want.mode)
                    report_mismatch($sformatf("mode %0d, expected %0d", o_mode, want.mode));
            end
        end
    end

    function automatic void push_cmd(t_cmd c, logic [LEVEL_W-1:0] arg);
        t_item it;
        it.kind      = KIND_COMMAND;
        it.command   = c;
        it.level_arg = arg;
        pending_reqs.push_back(it);
    endfunction

    // ticks carry random, ignored command and argument bits
    function automatic void push_ticks(int n);
        t_item it;
        repeat (n) begin
            it.kind      = KIND_TICK;
            it.command   = t_cmd'(3'($urandom_range(0, 7)));
            it.level_arg = 10'($urandom_range(0, 1023));
            pending_reqs.push_back(it);
        end
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1023;
            2: return $urandom_range(0, 3);
            3: return $urandom_range(1020, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_lamp.size() != 0);
    endtask

    task automatic set_interval(input logic [TICK_W-1:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        m_interval  = v;
        n_cfg++;
    endtask

    // mostly short effect sequences with random content, some single-item noise
    task automatic random_burst(input int n);
        int start, x, y, steps;
        start = pending_reqs.size();
        while (pending_reqs.size() - start < n) begin
            steps = $urandom_range(1, 6) * (int'(m_interval) + 1);
            if (steps > 48) steps = 48;
            x = pick_level();
            case ($urandom_range(0, 9))
                0, 1: begin
                    y = x + int'($urandom_range(0, 8)) - 4;
                    if (y < 0) y = 0;
                    if (y > 1023) y = 1023;
                    push_cmd(CMD_SET_LEVEL, 10'(x));
                    push_cmd(CMD_DIM_TO, 10'(y));
                    push_ticks(steps);
                end
                2: begin
                    push_cmd(CMD_SET_LEVEL, 10'($urandom_range(0, 4)));
                    push_cmd(CMD_DIM_DOWN, 10'($urandom_range(0, 1023)));
                    push_ticks(steps);
                end
                3: begin
                    if ($urandom_range(0, 1))
                        push_cmd(CMD_SET_LEVEL, 10'($urandom_range(0, 5)));
                    push_cmd(CMD_PULSE, 10'(x));
                    push_ticks(steps);
                end
                4: begin
                    if ($urandom_range(0, 1))
                        push_cmd(CMD_SET_LEVEL, 10'(x));
                    push_cmd(CMD_FLASH, 10'($urandom_range(0, 1023)));
                    push_ticks(steps);
                end
                5: begin
                    push_cmd(t_cmd'(3'($urandom_range(0, 3))), 10'(x));
                    push_ticks($urandom_range(0, 4));
                end
                default: begin
                    if ($urandom_range(0, 9) < 6)
                        push_ticks(1);
                    else
                        push_cmd(t_cmd'(3'($urandom_range(0, 7))), 10'(x));
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset interval: ticks accumulate while off, first flash step is immediate
        push_ticks(1);
        push_cmd(CMD_DIM_DOWN, 10'd0);
        push_cmd(CMD_SET_LEVEL, 10'd1023);
        push_cmd(CMD_SET_LEVEL, 10'd0);
        push_cmd(CMD_ON, 10'd0);
        push_cmd(CMD_STOP, 10'd1023);
        push_cmd(CMD_OFF, 10'd1023);
        push_ticks(9);
        push_cmd(CMD_FLASH, 10'd0);
        push_ticks(1);

        set_interval(16'd0);
        push_cmd(CMD_OFF, 10'd0);
        push_cmd(CMD_PULSE, 10'd0);
        push_ticks(2);
        push_cmd(CMD_SET_LEVEL, 10'd5);
        push_cmd(CMD_DIM_TO, 10'd5);
        push_ticks(1);
        push_cmd(CMD_SET_LEVEL, 10'd1022);
        push_ticks(1);
        push_cmd(CMD_SET_LEVEL, 10'd1);
        push_cmd(CMD_DIM_DOWN, 10'd0);
        push_ticks(1);
        random_burst(40);

        set_interval(16'd1);
        random_burst(80);
        set_interval(16'd2);
        random_burst(80);
        set_interval(16'd3);
        random_burst(60);

        // widest interval: ticks pile up while on, a dim never reaches a step
        set_interval(16'hFFFF);
        push_cmd(CMD_ON, 10'd0);
        push_ticks(20);
        push_cmd(CMD_DIM_TO, 10'd1020);
        push_ticks(12);

        set_interval(16'd7);
        random_burst(40);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_lamp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_lamp.size()));
        $display("covered %0d requests, %0d results checked", n_requests, n_results);
        $display("step interval written %0d times, from 0 up to 65535", n_cfg);
        if (n_errors == 0) begin
            $display("[led_dimmer_effect_controller] OK");
        end else begin
            $display("[led_dimmer_effect_controller] ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_lamp.size());
        $display("[led_dimmer_effect_controller] ERROR");
        $finish;
    end

endmodule
